### rtl/longest_increasing_subsequence_macros.svh
// Assertion macros used by the longest increasing subsequence RTL.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_MACROS_SVH

`ifndef SYNTHESIS
`define LIS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/lis_pkg.sv
// Package with the types and constants of the longest increasing subsequence block.
`timescale 1ns / 1ps
package lis_pkg;

	localparam int VAL_W = 32;
	localparam int LEN_W = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_CMP,
		ST_WRITE,
		ST_DONE
	} lis_state_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             final_res;
		logic             overflow;
	} lis_res_t;

endpackage

### rtl/lis_if.sv
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
interface lis_in_if;
	import lis_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface lis_out_if;
	import lis_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] length;
	logic             final_res;
	logic             overflow;

	modport source (output valid, output length, output final_res, output overflow,
		input ready);
	modport sink (input valid, input length, input final_res, input overflow,
		output ready);
endinterface

### rtl/lis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module lis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/lis_search.sv
// Binary search sequencer over the tail memory, with length and overflow state.
`timescale 1ns / 1ps
`include "longest_increasing_subsequence_macros.svh"
module lis_search #(
	parameter int MAX_LEN = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [lis_pkg::VAL_W-1:0] value,
	input  logic                             last,
	output logic                             ready,
	output logic                             done,
	output lis_pkg::lis_res_t                res,
	input  logic                             take
);
	import lis_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);

	lis_state_t state_q, state_d;
	logic [LW-1:0] lo_q, hi_q, mid_q, len_q;
	logic [LW-1:0] diff, mid;
	logic ovf_q, last_q;
	logic signed [VAL_W-1:0] v_q;
	logic signed [VAL_W-1:0] rdata;
	logic re, we, lo_lt_hi, is_append, room;
	logic searching, clear_seq;
	logic [LW+LEN_W-1:0] len_ext;

	assign diff = hi_q - lo_q;
	assign mid = lo_q + (diff >> 1);
	assign lo_lt_hi = lo_q < hi_q;
	assign is_append = lo_q == len_q;
	assign room = len_q < LW'(MAX_LEN);
	assign searching = state_q == ST_SRCH || state_q == ST_CMP;
	assign clear_seq = state_q == ST_DONE && take && last_q;

	lis_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_LEN)
	) u_tails (
		.clk  (clk),
		.we   (we),
		.waddr(lo_q[AW-1:0]),
		.wdata(v_q),
		.re   (re),
		.raddr(mid[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_SRCH;
			ST_SRCH:  state_d = lo_lt_hi ? ST_CMP : ST_WRITE;
			ST_CMP:   state_d = ST_SRCH;
			ST_WRITE: state_d = ST_DONE;
			ST_DONE:  if (take) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready = 1'b0;
		done  = 1'b0;
		re    = 1'b0;
		we    = 1'b0;
		unique case (state_q)
			ST_IDLE:  ready = 1'b1;
			ST_SRCH:  re = lo_lt_hi;
			ST_CMP:   ;
			ST_WRITE: we = !is_append || room;
			ST_DONE:  done = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WRITE && is_append) begin
				if (room) begin
					len_q <= len_q + LW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (clear_seq) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			v_q    <= value;
			last_q <= last;
			lo_q   <= '0;
			hi_q   <= len_q;
		end
		if (state_q == ST_SRCH) begin
			mid_q <= mid;
		end
		if (state_q == ST_CMP) begin
			if (rdata < v_q) begin
				lo_q <= mid_q + LW'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
	end

	assign len_ext = {{LEN_W{1'b0}}, len_q};
	assign res.length = len_ext[LEN_W-1:0];
	assign res.final_res = last_q;
	assign res.overflow = ovf_q;

	`LIS_ASSERT(a_len_cap, clk, arst_n, len_q <= LW'(MAX_LEN), "length beyond capacity")
	`LIS_ASSERT(a_bounds, clk, arst_n, !searching || (lo_q <= hi_q && hi_q <= len_q), "bounds crossed")
	`LIS_ASSERT(a_mid, clk, arst_n, state_q != ST_CMP || mid_q < len_q, "probe outside table")
	`LIS_ASSERT_NEXT(a_clear, clk, arst_n, clear_seq, len_q == '0 && !ovf_q, "state kept after last word")
endmodule

### rtl/longest_increasing_subsequence.sv
// Top level of the longest strictly increasing subsequence block.
//
// Each input word on din carries one signed 32-bit element and a last flag.
// Every accepted word yields exactly one result word on dout: the running
// length of the longest strictly increasing subsequence, final_res set when
// the element was marked last, and overflow set once the tail table of
// MAX_LEN entries was full and an append was dropped in this sequence.
// After a result with final_res set, the length and overflow state restart.
// After an element is accepted, the binary search issues one tail memory read
// and one compare per step, followed by a write state, before its result is
// offered to the output register. Once it has handed its result over, the
// sequencer returns to idle, where the next word is accepted.
// One element is in flight at a time; din.ready is high only while the
// sequencer waits for a word. A finished result sits in the output register
// while the next word is accepted; if dout stalls with a result still held,
// the sequencer keeps its new result until the register frees.
// Reset clears the length, overflow and handshake state; the tail memory is
// not cleared, since only entries already written in a sequence are read.
`timescale 1ns / 1ps
module longest_increasing_subsequence #(
	parameter int MAX_LEN = 1024
) (
	input logic       clk,
	input logic       arst_n,
	lis_in_if.sink    din,
	lis_out_if.source dout
);
	import lis_pkg::*;

	logic     done, take, out_valid_q;
	lis_res_t res, out_q;

	assign take = done && (!out_valid_q || dout.ready);

	lis_search #(
		.MAX_LEN(MAX_LEN)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (din.valid),
		.value (din.value),
		.last  (din.last),
		.ready (din.ready),
		.done  (done),
		.res   (res),
		.take  (take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.length    = out_q.length;
	assign dout.final_res = out_q.final_res;
	assign dout.overflow  = out_q.overflow;
endmodule

### dv/longest_increasing_subsequence_tb.sv
// Self-checking testbench for the longest increasing subsequence block.
`timescale 1ns / 1ps
module longest_increasing_subsequence_tb;
	import lis_pkg::*;

	localparam int TAIL_DEPTH = 1024;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {
		PAT_WIDE,
		PAT_NARROW,
		PAT_RISING,
		PAT_EXTREME
	} value_pattern_t;

	class lis_scoreboard;
		logic signed [VAL_W-1:0] tails [TAIL_DEPTH];
		int unsigned run_len;
		bit run_overflow;
		lis_res_t pending_len [$];
		int errors;
		int words_in;
		int sequences_done;
		int peak_len;
		int overflow_results;

		function void note_word(logic signed [VAL_W-1:0] v, logic is_last);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lis_res_t r;
			words_in++;
			if (run_len == 0 || v > tails[run_len - 1]) begin
				if (run_len < TAIL_DEPTH) begin
					tails[run_len] = v;
					run_len++;
				end else begin
					run_overflow = 1'b1;
				end
			end else begin
				lo = 0;
				hi = run_len;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (tails[mid] < v) lo = mid + 1;
					else hi = mid;
				end
				if (lo < run_len) tails[lo] = v;
			end
			r.length = LEN_W'(run_len);
			r.final_res = is_last;
			r.overflow = run_overflow;
			pending_len = {pending_len, r};
			if (run_len > peak_len) peak_len = run_len;
			if (is_last) begin
				sequences_done++;
				run_len = 0;
				run_overflow = 1'b0;
			end
		endfunction

		function void check_word(lis_res_t got);
			lis_res_t want;
			if (pending_len.size() == 0) begin
				$error("Unexpected result word: length %0d, final_res %0b, overflow %0b",
					got.length, got.final_res, got.overflow);
				errors++;
				return;
			end
			want = pending_len.pop_front();
			if (got.overflow) overflow_results++;
			if (got.length !== want.length) begin
				$error("length mismatch: expected %0d, actual %0d", want.length, got.length);
				errors++;
			end
			if (got.final_res !== want.final_res) begin
				$error("final_res mismatch: expected %0b, actual %0b",
					want.final_res, got.final_res);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow mismatch: expected %0b, actual %0b",
					want.overflow, got.overflow);
				errors++;
			end
		endfunction

		function bit idle();
			return pending_len.size() == 0;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int send_idle_pct;
	int recv_idle_pct;
	logic holding;
	event hold_go;
	lis_scoreboard sb = new;

	lis_in_if din_if();
	lis_out_if dout_if();

	longest_increasing_subsequence #(
		.MAX_LEN(TAIL_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if),
		.dout(dout_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (holding) dout_if.ready <= 1'b0;
		else dout_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		forever begin
			@(hold_go);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	always @(posedge clk) begin
		lis_res_t got;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			got.length = dout_if.length;
			got.final_res = dout_if.final_res;
			got.overflow = dout_if.overflow;
			sb.check_word(got);
		end
	end

	task automatic send_word(input logic signed [VAL_W-1:0] v, input logic is_last);
		int gap;
		din_if.valid <= 1'b1;
		din_if.value <= v;
		din_if.last <= is_last;
		do @(posedge clk); while (!din_if.ready);
		sb.note_word(v, is_last);
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		din_if.valid <= 1'b0;
		while (!sb.idle()) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_directed();
		logic signed [VAL_W-1:0] seq_a [8] = '{VAL_MAX, VAL_MIN, 0, 0, -1, 1, VAL_MAX, VAL_MAX};
		send_word(VAL_MIN, 1'b1);
		foreach (seq_a[i]) send_word(seq_a[i], i == $size(seq_a) - 1);
		repeat (3) send_word(5, 1'b0);
		send_word(5, 1'b1);
		for (int i = 3; i >= 1; i--) send_word(i, i == 1);
		for (int i = -2; i <= 2; i++) send_word(i, i == 2);
		send_word(32'sh5555_5555, 1'b0);
		send_word(32'shaaaa_aaaa, 1'b1);
	endtask

	task automatic run_random(input int n_words);
		int sent;
		int seq_len;
		value_pattern_t pat;
		logic signed [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] base;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(9) < 8) seq_len = $urandom_range(1, 30);
			else seq_len = $urandom_range(31, 300);
			if (seq_len > n_words - sent) seq_len = n_words - sent;
			pat = value_pattern_t'($urandom_range(3));
			base = $urandom_range(200) - 100;
			for (int i = 0; i < seq_len; i++) begin
				case (pat)
					PAT_WIDE: v = $urandom;
					PAT_NARROW: v = $urandom_range(16) - 8;
					PAT_RISING: begin
						if ($urandom_range(9) == 0) base = base - $urandom_range(50);
						else base = base + $urandom_range(5);
						v = base;
					end
					default: begin
						case ($urandom_range(5))
							0: v = VAL_MIN;
							1: v = VAL_MAX;
							2: v = 0;
							3: v = -1;
							4: v = 1;
							default: v = $urandom;
						endcase
					end
				endcase
				send_word(v, i == seq_len - 1);
			end
			sent += seq_len;
		end
	endtask

	// Fills the tail table past capacity, then mixes replacements and refused appends.
	task automatic run_full_table();
		for (int i = 0; i < TAIL_DEPTH + 4; i++) send_word(VAL_MIN + 2 * i, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word(VAL_MIN + 7, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN + 2 * (TAIL_DEPTH - 1), 1'b1);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		holding = 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 88;
		din_if.valid = 1'b0;
		din_if.value = '0;
		din_if.last = 1'b0;
		dout_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(20);
		drain_results();

		send_idle_pct = 88;
		recv_idle_pct = 35;
		run_random(20);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_full_table();
		drain_results();
		->hold_go;
		run_random(20);
		drain_results();

		$display("Summary: %0d words in %0d sequences, peak length %0d, %0d overflow results.",
			sb.words_in, sb.sequences_done, sb.peak_len, sb.overflow_results);
		$display("Idle patterns covered: sender-heavy, receiver-heavy, none, and a long stall.");
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout waiting for the block.");
		$display("Test completed with failures");
		$finish;
	end

endmodule
